/* src/sacf_pkg.sv */
// Shared types, constants and codes for the set-associative tag cache.
`timescale 1ns / 1ps
package sacf_pkg;

   // Fixed field widths of the request, the response and the set storage.
   localparam int ADDR_WIDTH = 48;
   localparam int CNT_WIDTH = 32;
   localparam int RANK_WIDTH = 3;
   localparam int FIFO_WIDTH = 3;
   localparam logic [RANK_WIDTH-1:0] RANK_MAX = 3'd7;

   // Default sizes of the storage.
   localparam int DEF_MAX_SETS = 256;
   localparam int DEF_MAX_WAYS = 8;

   // Access kinds.
   localparam logic OP_READ = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_OFFSET_BITS = 2'd0;
   localparam logic [1:0] CSR_SET_INDEX_BITS = 2'd1;
   localparam logic [1:0] CSR_WAYS_LOG2 = 2'd2;
   localparam logic [1:0] CSR_REPLACE_LRU = 2'd3;

   typedef struct packed {
      logic opcode;
      logic [ADDR_WIDTH-1:0] address;
   } req_type;

   typedef struct packed {
      logic hit;
      logic mem_read_done;
      logic mem_write_done;
      logic [CNT_WIDTH-1:0] total_reads;
      logic [CNT_WIDTH-1:0] total_writes;
      logic [CNT_WIDTH-1:0] total_hits;
      logic [CNT_WIDTH-1:0] total_misses;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic commit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic out_full;
   } sts_type;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE = 3'b010,
      ST_LOOK = 3'b100
   } state_type;

endpackage

/* src/set_assoc_cache_fifo_lru_top.sv */
// Top level of the set-associative tag cache with FIFO or LRU replacement.
//
//   channel  direction  handshake          payload
//   req      in         valid / stall      opcode, address
//   rsp      out        valid / stall      hit, traffic flags, four totals
//   csr      in         valid / ready      index (2 bits), data (4 bits)
//
// A request first reads its set row on accept; in ST_LOOK it is checked,
// updated and written back and the response register is loaded.
// After reset a clearing pass over all MAX_SETS sets zeroes valid bits, ranks
// and FIFO pointers; no request is taken during it, configuration writes are.
// A new request is taken while a response waits; a stalled response holds
// the next request in ST_LOOK until the response register frees.
`timescale 1ns / 1ps
module set_assoc_cache_fifo_lru_top #(
   parameter int MAX_SETS = sacf_pkg::DEF_MAX_SETS,
   parameter int MAX_WAYS = sacf_pkg::DEF_MAX_WAYS
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input sacf_pkg::req_type req_payload,
   output logic rsp_valid,
   input logic rsp_stall,
   output sacf_pkg::rsp_type rsp_payload,
   input logic csr_valid,
   output logic csr_ready,
   input logic [1:0] csr_index,
   input logic [3:0] csr_data
);
   import sacf_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Configuration is always writable.
   assign csr_ready = 1'b1;

   sacf_controller u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_stall(rsp_stall),
      .sts(sts),
      .cmd(cmd)
   );

   sacf_datapath #(
      .MAX_SETS(MAX_SETS),
      .MAX_WAYS(MAX_WAYS)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .sts(sts),
      .req_payload(req_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .rsp_valid(rsp_valid),
      .rsp_payload(rsp_payload),
      .rsp_stall(rsp_stall)
   );

   // Only one command is issued in a cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear_wr, cmd.accept, cmd.commit}))
      else $error("more than one command at once");

   // A commit always leaves a response waiting.
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("commit without response");

   // An accepted request is followed by its commit phase, not a new accept.
   assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (req_stall && !cmd.accept))
      else $error("request accepted twice in a row");

endmodule

/* src/sacf_datapath.sv */
// Datapath: configuration, set memories, lookup, replacement and counters.
`timescale 1ns / 1ps
module sacf_datapath #(
   parameter int MAX_SETS = sacf_pkg::DEF_MAX_SETS,
   parameter int MAX_WAYS = sacf_pkg::DEF_MAX_WAYS
) (
   input logic clock,
   input logic reset,
   input sacf_pkg::cmd_type cmd,
   output sacf_pkg::sts_type sts,
   input sacf_pkg::req_type req_payload,
   input logic csr_valid,
   input logic csr_ready,
   input logic [1:0] csr_index,
   input logic [3:0] csr_data,
   output logic rsp_valid,
   output sacf_pkg::rsp_type rsp_payload,
   input logic rsp_stall
);
   import sacf_pkg::*;

   localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   // Largest geometry that fits the storage: floor of log2.
   localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1;
   localparam int WL_MAX = $clog2(MAX_WAYS + 1) - 1;
   localparam logic [SET_W-1:0] LAST_SET = SET_W'(MAX_SETS - 1);

   // Configuration registers.
   logic [3:0] offset_bits_ff;
   logic [3:0] set_index_bits_ff;
   logic [1:0] ways_log2_ff;
   logic replace_lru_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff <= 4'd4;
         set_index_bits_ff <= 4'd0;
         ways_log2_ff <= 2'd0;
         replace_lru_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_OFFSET_BITS: offset_bits_ff <= csr_data;
            CSR_SET_INDEX_BITS: set_index_bits_ff <= csr_data;
            CSR_WAYS_LOG2: ways_log2_ff <= csr_data[1:0];
            CSR_REPLACE_LRU: replace_lru_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Effective geometry after clamping to the built storage.
   logic [4:0] sb_eff;
   logic [2:0] wl_eff;
   assign sb_eff = (int'(set_index_bits_ff) > SB_MAX) ? 5'(SB_MAX) : 5'(set_index_bits_ff);
   assign wl_eff = (int'(ways_log2_ff) > WL_MAX) ? 3'(WL_MAX) : 3'(ways_log2_ff);

   // Address split of the incoming request.
   logic [ADDR_WIDTH-1:0] shifted;
   logic [ADDR_WIDTH-1:0] set_mask;
   logic [SET_W-1:0] set_in;
   logic [ADDR_WIDTH-1:0] tag_in;
   logic [5:0] tag_shift;
   assign shifted = req_payload.address >> offset_bits_ff;
   assign set_mask = ~({ADDR_WIDTH{1'b1}} << sb_eff);
   assign set_in = SET_W'(shifted & set_mask);
   assign tag_shift = 6'(offset_bits_ff) + 6'(sb_eff);
   assign tag_in = req_payload.address >> tag_shift;

   // Request registers.
   logic [SET_W-1:0] set_ff;
   logic [ADDR_WIDTH-1:0] tag_ff;
   logic write_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         set_ff <= set_in;
         tag_ff <= tag_in;
         write_ff <= (req_payload.opcode == OP_WRITE);
      end
   end

   // Clearing pass counter.
   logic [SET_W-1:0] clr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_wr) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end
   assign sts.clear_last = (clr_ff == LAST_SET);

   // Set memories with registered reads.
   logic [MAX_WAYS-1:0] valid_mem [MAX_SETS];
   logic [MAX_WAYS-1:0][RANK_WIDTH-1:0] rank_mem [MAX_SETS];
   logic [FIFO_WIDTH-1:0] fifo_mem [MAX_SETS];
   logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_mem [MAX_SETS];

   logic [MAX_WAYS-1:0] valid_rd;
   logic [MAX_WAYS-1:0][RANK_WIDTH-1:0] rank_rd;
   logic [FIFO_WIDTH-1:0] fifo_rd;
   logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_rd;

   logic [MAX_WAYS-1:0] valid_wr;
   logic [MAX_WAYS-1:0][RANK_WIDTH-1:0] rank_wr;
   logic [FIFO_WIDTH-1:0] fifo_wr;
   logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_wr;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         valid_rd <= valid_mem[set_in];
         rank_rd <= rank_mem[set_in];
         fifo_rd <= fifo_mem[set_in];
         tag_rd <= tag_mem[set_in];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         valid_mem[clr_ff] <= '0;
         rank_mem[clr_ff] <= '0;
         fifo_mem[clr_ff] <= '0;
      end else if (cmd.commit) begin
         valid_mem[set_ff] <= valid_wr;
         rank_mem[set_ff] <= rank_wr;
         fifo_mem[set_ff] <= fifo_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         tag_mem[set_ff] <= tag_wr;
      end
   end

   // Lookup and replacement on the set read back.
   logic hit;
   logic [WAY_W-1:0] way;

   always_comb begin
      logic [MAX_WAYS-1:0] in_use;
      logic [MAX_WAYS-1:0] prefix;
      logic inv_found;
      logic [WAY_W-1:0] inv_way;
      logic [WAY_W-1:0] lru_way;
      logic [WAY_W-1:0] fifo_way;
      logic [RANK_WIDTH-1:0] old_rank;
      int nways;
      hit = 1'b0;
      way = '0;
      inv_found = 1'b0;
      inv_way = '0;
      lru_way = '0;
      nways = 1 << wl_eff;
      for (int w = 0; w < MAX_WAYS; w++) begin
         in_use[w] = (w < nways);
      end
      // Scan stops at the first invalid way.
      prefix[0] = in_use[0] && valid_rd[0];
      for (int w = 1; w < MAX_WAYS; w++) begin
         prefix[w] = prefix[w-1] && in_use[w] && valid_rd[w];
      end
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (prefix[w] && tag_rd[w] == tag_ff) begin
            hit = 1'b1;
            way = WAY_W'(w);
         end
         if (in_use[w] && !valid_rd[w]) begin
            inv_found = 1'b1;
            inv_way = WAY_W'(w);
         end
      end
      // Oldest way in use, lowest way on a tie.
      for (int w = 1; w < MAX_WAYS; w++) begin
         if (in_use[w] && rank_rd[w] > rank_rd[lru_way]) begin
            lru_way = WAY_W'(w);
         end
      end
      fifo_way = WAY_W'(int'(fifo_rd) & (nways - 1));

      valid_wr = valid_rd;
      tag_wr = tag_rd;
      fifo_wr = fifo_rd;
      if (!hit) begin
         if (inv_found) begin
            way = inv_way;
         end else if (replace_lru_ff) begin
            way = lru_way;
         end else begin
            way = fifo_way;
            fifo_wr = fifo_rd + 1'b1;
         end
         valid_wr[way] = 1'b1;
         tag_wr[way] = tag_ff;
      end

      // Recency update of the touched way, in LRU mode only.
      rank_wr = rank_rd;
      old_rank = rank_rd[way];
      if (replace_lru_ff) begin
         for (int w = 0; w < MAX_WAYS; w++) begin
            if (in_use[w] && WAY_W'(w) != way && rank_rd[w] <= old_rank
                && rank_rd[w] < RANK_MAX) begin
               rank_wr[w] = rank_rd[w] + 1'b1;
            end
         end
         rank_wr[way] = '0;
      end
   end

   // Saturating totals.
   logic [CNT_WIDTH-1:0] reads_ff, writes_ff, hits_ff, misses_ff;
   logic [CNT_WIDTH-1:0] reads_in, writes_in, hits_in, misses_in;

   function automatic logic [CNT_WIDTH-1:0] sat_inc(input logic [CNT_WIDTH-1:0] c,
                                                    input logic en);
      sat_inc = (en && c != {CNT_WIDTH{1'b1}}) ? c + 1'b1 : c;
   endfunction

   assign hits_in = sat_inc(hits_ff, hit);
   assign misses_in = sat_inc(misses_ff, !hit);
   assign reads_in = sat_inc(reads_ff, !hit);
   assign writes_in = sat_inc(writes_ff, write_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         reads_ff <= '0;
         writes_ff <= '0;
         hits_ff <= '0;
         misses_ff <= '0;
      end else if (cmd.commit) begin
         reads_ff <= reads_in;
         writes_ff <= writes_in;
         hits_ff <= hits_in;
         misses_ff <= misses_in;
      end
   end

   // Response register.
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff.hit <= hit;
         rsp_ff.mem_read_done <= !hit;
         rsp_ff.mem_write_done <= write_ff;
         rsp_ff.total_reads <= reads_in;
         rsp_ff.total_writes <= writes_in;
         rsp_ff.total_hits <= hits_in;
         rsp_ff.total_misses <= misses_in;
      end
   end

   assign sts.out_full = rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* src/sacf_controller.sv */
// Controller: clearing pass after reset, request accept and commit sequencing.
`timescale 1ns / 1ps
module sacf_controller (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic rsp_stall,
   input sacf_pkg::sts_type sts,
   output sacf_pkg::cmd_type cmd
);
   import sacf_pkg::*;

   state_type state_ff, state_in;
   logic out_free;

   // The response register can take a new result this cycle.
   assign out_free = !sts.out_full || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule
